[rtl/core/omts_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// omts_pkg
// Shared constants, types and helpers for the objectness mask tile selector.
// ----------------------------------------------------------------------------
package omts_pkg;

   localparam int MASK_SCALE     = 8;
   localparam int SCALE_SHIFT    = $clog2(MASK_SCALE);
   localparam int MASK_COLS      = 256;
   localparam int MASK_ROWS      = 256;
   localparam int MAX_GRID_TILES = 1023;
   localparam int COUNT_LIMIT    = (MAX_GRID_TILES < 1023) ? MAX_GRID_TILES : 1023;

   localparam int COL_W      = $clog2(MASK_COLS);
   localparam int ROW_W      = $clog2(MASK_ROWS);
   localparam int MASK_DEPTH = MASK_ROWS * MASK_COLS;
   localparam int ADDR_W     = $clog2(MASK_DEPTH);
   localparam int CELL_W     = 16;
   localparam int EPOCH_W    = 8;
   localparam int EDGE_W     = 13;
   localparam int CNT_W      = 10;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 56;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_THRESHOLD    = 3'd2,
      CSR_FALLBACK     = 3'd3,
      CSR_MAX_TILES    = 3'd4,
      CSR_DENSE        = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_PAINT = 2'd1,
      OP_QUERY = 2'd2,
      OP_END   = 2'd3
   } op_type;

   localparam logic KIND_VERDICT = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      op_type      operation;
      logic [12:0] box_left;
      logic [12:0] box_top;
      logic [12:0] box_right;
      logic [12:0] box_bottom;
      logic [15:0] box_confidence;
      logic [10:0] tile_left;
      logic [10:0] tile_top;
      logic [11:0] tile_width;
      logic [11:0] tile_height;
   } req_type;

   typedef struct packed {
      logic             result_kind;
      logic [CNT_W-1:0] tile_number;
      logic [15:0]      tile_peak;
      logic             tile_active;
      logic             tile_selected;
      logic             grid_fallback;
      logic             was_capped;
      logic [CNT_W-1:0] active_count;
      logic [CNT_W-1:0] tiles_seen;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic setup;
      logic walk;
      logic sweep;
      logic finish;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      op_type op;
      logic   empty;
      logic   walk_last;
      logic   sweep_last;
      logic   epoch_full;
      logic   out_free;
   } stat_type;

   // signed pixel to cell edge: truncating divide, floored at zero
   function automatic logic [EDGE_W-1:0] cell_of(input logic [12:0] px);
      logic [EDGE_W-1:0] r;
      r = px[12] ? '0 : (EDGE_W'(px) >> SCALE_SHIFT);
      return r;
   endfunction

   // mask extent for a frame dimension, limited to the stored size
   function automatic logic [EDGE_W-1:0] mask_span(input logic [10:0] dim,
                                                   input logic [EDGE_W-1:0] cap);
      logic [EDGE_W-1:0] n;
      n = (EDGE_W'(dim) >> SCALE_SHIFT) + EDGE_W'(1);
      return (n > cap) ? cap : n;
   endfunction

endpackage
`default_nettype wire

[rtl/core/omts_mask_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// omts_mask_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module omts_mask_ram #(
   parameter int DATA_W = 24,
   parameter int ADDR_W = 16,
   parameter int DEPTH  = 65536
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/core/omts_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// omts_ctrl
// Sequencer: accepts a beat, sets up the cell walk, drains the read pipe and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module omts_ctrl import omts_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire stat_type stat,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   output cmd_type       cmd
);

   typedef enum logic [5:0] {
      ST_SWEEP  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_SETUP  = 6'b000100,
      ST_WALK   = 6'b001000,
      ST_DRAIN  = 6'b010000,
      ST_FINISH = 6'b100000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SWEEP: begin
            if (stat.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            case (stat.op)
               OP_CLEAR: state_in = stat.epoch_full ? ST_SWEEP : ST_IDLE;
               OP_PAINT: state_in = stat.empty ? ST_IDLE : ST_WALK;
               OP_QUERY: state_in = stat.empty ? ST_FINISH : ST_WALK;
               OP_END:   state_in = ST_FINISH;
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_WALK: begin
            if (stat.walk_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = (stat.op == OP_PAINT) ? ST_IDLE : ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd.load   = (state_ff == ST_IDLE) && req_tvalid;
      cmd.setup  = (state_ff == ST_SETUP);
      cmd.walk   = (state_ff == ST_WALK);
      cmd.sweep  = (state_ff == ST_SWEEP);
      cmd.finish = (state_ff == ST_FINISH) && stat.out_free;
   end

endmodule
`default_nettype wire

[rtl/core/omts_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// omts_datapath
// Config registers, cell walker, epoch-tagged mask memory, peak/paint logic,
// tile counters and the result register.
// ----------------------------------------------------------------------------
module omts_datapath import omts_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output stat_type                   stat,
   input  wire req_type               req_item,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic                  rsp_tready,
   output logic                       rsp_valid,
   output rsp_type                    rsp_item
);

   localparam logic [CNT_W-1:0]  CNT_LIM  = CNT_W'(COUNT_LIMIT);
   localparam logic [EDGE_W-1:0] COLS_CAP = EDGE_W'(MASK_COLS);
   localparam logic [EDGE_W-1:0] ROWS_CAP = EDGE_W'(MASK_ROWS);
   localparam int                WORD_W   = EPOCH_W + CELL_W;

   // configuration
   logic [10:0]      width_ff, width_in;
   logic [10:0]      height_ff, height_in;
   logic [15:0]      thr_ff, thr_in;
   logic             fallback_ff, fallback_in;
   logic [CNT_W-1:0] max_tiles_ff, max_tiles_in;
   logic             dense_ff, dense_in;

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      thr_in       = thr_ff;
      fallback_in  = fallback_ff;
      max_tiles_in = max_tiles_ff;
      dense_in     = dense_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_in     = csr_data[10:0];
            CSR_IMAGE_HEIGHT: height_in    = csr_data[10:0];
            CSR_THRESHOLD:    thr_in       = csr_data;
            CSR_FALLBACK:     fallback_in  = csr_data[0];
            CSR_MAX_TILES:    max_tiles_in = csr_data[CNT_W-1:0];
            CSR_DENSE:        dense_in     = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= 11'd640;
         height_ff    <= 11'd640;
         thr_ff       <= 16'd9830;
         fallback_ff  <= 1'b1;
         max_tiles_ff <= CNT_W'(64);
         dense_ff     <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         thr_ff       <= thr_in;
         fallback_ff  <= fallback_in;
         max_tiles_ff <= max_tiles_in;
         dense_ff     <= dense_in;
      end
   end

   // held beat
   req_type item_ff, item_in;
   assign item_in = cmd.load ? req_item : item_ff;

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   // cell range of the held beat
   logic [EDGE_W-1:0] mw, mh, x1, y1, x2, y2, x2c, y2c;
   logic              range_empty;

   always_comb begin
      mw = mask_span(width_ff, COLS_CAP);
      mh = mask_span(height_ff, ROWS_CAP);
      if (item_ff.operation == OP_PAINT) begin
         x1 = cell_of(item_ff.box_left);
         y1 = cell_of(item_ff.box_top);
         x2 = cell_of(item_ff.box_right);
         y2 = cell_of(item_ff.box_bottom);
      end else begin
         x1 = EDGE_W'(item_ff.tile_left) >> SCALE_SHIFT;
         y1 = EDGE_W'(item_ff.tile_top) >> SCALE_SHIFT;
         x2 = (EDGE_W'(item_ff.tile_left) + EDGE_W'(item_ff.tile_width)) >> SCALE_SHIFT;
         y2 = (EDGE_W'(item_ff.tile_top) + EDGE_W'(item_ff.tile_height)) >> SCALE_SHIFT;
      end
      x2c = (x2 > mw) ? mw : x2;
      y2c = (y2 > mh) ? mh : y2;
      range_empty = (x2c <= x1) || (y2c <= y1);
   end

   // cell walker
   logic [COL_W-1:0]  col_ff, col_in, col_start_ff, col_start_in, col_last_ff, col_last_in;
   logic [ROW_W-1:0]  row_ff, row_in, row_last_ff, row_last_in;
   logic [ADDR_W-1:0] walk_addr;
   logic              walk_last;

   assign walk_addr = ADDR_W'(row_ff) * ADDR_W'(MASK_COLS) + ADDR_W'(col_ff);
   assign walk_last = (col_ff == col_last_ff) && (row_ff == row_last_ff);

   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      col_start_in = col_start_ff;
      col_last_in  = col_last_ff;
      row_last_in  = row_last_ff;
      if (cmd.setup) begin
         col_in       = COL_W'(x1);
         col_start_in = COL_W'(x1);
         col_last_in  = COL_W'(x2c - EDGE_W'(1));
         row_in       = ROW_W'(y1);
         row_last_in  = ROW_W'(y2c - EDGE_W'(1));
      end else if (cmd.walk) begin
         if (col_ff == col_last_ff) begin
            col_in = col_start_ff;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      row_ff       <= row_in;
      col_start_ff <= col_start_in;
      col_last_ff  <= col_last_in;
      row_last_ff  <= row_last_in;
   end

   // read pipe: data for the address issued last cycle arrives now
   logic              pend_valid_ff, pend_valid_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;

   assign pend_valid_in = cmd.walk;
   assign pend_addr_in  = walk_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
      pend_addr_ff <= pend_addr_in;
   end

   // epoch mark: a clear bumps the epoch, stale tags read as zero.
   // when the epoch would wrap, the whole memory is swept back to tag zero.
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   logic               clear_now;

   assign clear_now = cmd.setup && (item_ff.operation == OP_CLEAR);

   always_comb begin
      epoch_in = epoch_ff;
      sweep_in = sweep_ff;
      if (clear_now) begin
         if (&epoch_ff) begin
            epoch_in = '0;
            sweep_in = '0;
         end else begin
            epoch_in = epoch_ff + EPOCH_W'(1);
         end
      end else if (cmd.sweep) begin
         sweep_in = sweep_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff <= '0;
         sweep_ff <= '0;
      end else begin
         epoch_ff <= epoch_in;
         sweep_ff <= sweep_in;
      end
   end

   // mask memory
   logic [WORD_W-1:0] rd_word, wr_word;
   logic [ADDR_W-1:0] wr_addr;
   logic              wr_en;
   logic [CELL_W-1:0] cell_val, painted;

   assign cell_val = (rd_word[WORD_W-1:CELL_W] == epoch_ff) ? rd_word[CELL_W-1:0] : '0;
   assign painted  = (cell_val > item_ff.box_confidence) ? cell_val : item_ff.box_confidence;

   always_comb begin
      if (cmd.sweep) begin
         wr_en   = 1'b1;
         wr_addr = sweep_ff;
         wr_word = '0;
      end else begin
         wr_en   = pend_valid_ff && (item_ff.operation == OP_PAINT);
         wr_addr = pend_addr_ff;
         wr_word = {epoch_ff, painted};
      end
   end

   omts_mask_ram #(
      .DATA_W (WORD_W),
      .ADDR_W (ADDR_W),
      .DEPTH  (MASK_DEPTH)
   ) u_mask_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (cmd.walk),
      .rd_addr (walk_addr),
      .rd_data (rd_word)
   );

   // tile peak
   logic [CELL_W-1:0] peak_ff, peak_in;

   always_comb begin
      peak_in = peak_ff;
      if (cmd.setup) begin
         peak_in = '0;
      end else if (pend_valid_ff && (item_ff.operation == OP_QUERY) && (cell_val > peak_ff)) begin
         peak_in = cell_val;
      end
   end

   always_ff @(posedge clock) begin
      peak_ff <= peak_in;
   end

   // verdicts and counters
   logic [CNT_W-1:0] active_total_ff, active_total_in, tile_total_ff, tile_total_in;
   logic [CNT_W-1:0] act_next, tile_next, chosen;
   logic             active, selected, fallback_now, capped;
   rsp_type          result;

   always_comb begin
      active       = dense_ff || (peak_ff > thr_ff);
      selected     = active && (active_total_ff < max_tiles_ff);
      act_next     = (active && (active_total_ff < CNT_LIM)) ?
                     active_total_ff + CNT_W'(1) : active_total_ff;
      tile_next    = (tile_total_ff < CNT_LIM) ? tile_total_ff + CNT_W'(1) : tile_total_ff;
      fallback_now = !dense_ff && (active_total_ff == '0) && fallback_ff &&
                     (tile_total_ff != '0);
      chosen       = fallback_now ? tile_total_ff : active_total_ff;
      capped       = chosen > max_tiles_ff;

      result = '0;
      if (item_ff.operation == OP_QUERY) begin
         result.result_kind   = KIND_VERDICT;
         result.tile_number   = tile_total_ff;
         result.tile_peak     = peak_ff;
         result.tile_active   = active;
         result.tile_selected = selected;
         result.active_count  = act_next;
         result.tiles_seen    = tile_next;
      end else begin
         result.result_kind   = KIND_SUMMARY;
         result.grid_fallback = fallback_now;
         result.was_capped    = capped;
         result.active_count  = active_total_ff;
         result.tiles_seen    = tile_total_ff;
      end

      active_total_in = active_total_ff;
      tile_total_in   = tile_total_ff;
      if (clear_now) begin
         active_total_in = '0;
         tile_total_in   = '0;
      end else if (cmd.finish && (item_ff.operation == OP_QUERY)) begin
         active_total_in = act_next;
         tile_total_in   = tile_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_total_ff <= '0;
         tile_total_ff   <= '0;
      end else begin
         active_total_ff <= active_total_in;
         tile_total_ff   <= tile_total_in;
      end
   end

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    out_free;

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = cmd.finish ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   assign rsp_in       = cmd.finish ? result : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      stat.op         = item_ff.operation;
      stat.empty      = range_empty;
      stat.walk_last  = walk_last;
      stat.sweep_last = (sweep_ff == ADDR_W'(MASK_DEPTH - 1));
      stat.epoch_full = &epoch_ff;
      stat.out_free   = out_free;
   end

   // no read may be in flight while the sweep owns the write port
   a_sweep_no_read: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep |-> !pend_valid_ff)
      else $error("read in flight during sweep");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> (col_ff <= col_last_ff) && (row_ff <= row_last_ff))
      else $error("walker outside cell range");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten");

   a_count_order: assert property (@(posedge clock) disable iff (reset)
      active_total_ff <= tile_total_ff)
      else $error("active count above tile count");

endmodule
`default_nettype wire

[rtl/core/objectness_mask_tile_selector.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// objectness_mask_tile_selector
// Coarse objectness mask with box painting, tile peak queries and tile
// selection summary.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  req_tdata (120b), req_tuser (op)
//  rsp      out        rsp_tvalid/rsp_tready  rsp_tdata (56b), rsp_tuser (kind)
//  csr      in         csr_valid/csr_ready    csr_index (3b), csr_data (16b)
//
//  After setup, a paint or query walks the mask cells it covers and drains the read
//  pipe, a query or end beat then loads the output register, and a beat covering
//  no cell skips walk and drain. The mask memory port reads one cell a cycle.
//  Every 256th clear adds a sweep of all 65536 mask words; reset runs the same sweep
//  before req_tready first rises. A finished result waits in the output register
//  while the next beat is taken; a query or end beat stalls only if it is still full.
// ----------------------------------------------------------------------------
module objectness_mask_tile_selector import omts_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // box_left, box_top, box_right, box_bottom, box_confidence,
   // tile_left, tile_top, tile_width, tile_height
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // operation
   input  wire logic [1:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tile_number, tile_peak, tile_active, tile_selected, grid_fallback,
   // was_capped, active_count, tiles_seen
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // result_kind
   output logic                       rsp_tuser,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;
   req_type  req_item;
   rsp_type  rsp_item;

   always_comb begin
      req_item.operation      = op_type'(req_tuser);
      req_item.box_left       = req_tdata[12:0];
      req_item.box_top        = req_tdata[25:13];
      req_item.box_right      = req_tdata[38:26];
      req_item.box_bottom     = req_tdata[51:39];
      req_item.box_confidence = req_tdata[67:52];
      req_item.tile_left      = req_tdata[78:68];
      req_item.tile_top       = req_tdata[89:79];
      req_item.tile_width     = req_tdata[101:90];
      req_item.tile_height    = req_tdata[113:102];
   end

   assign csr_ready = 1'b1;

   omts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .stat       (stat),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   omts_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_item   (req_item),
      .csr_write  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_item   (rsp_item)
   );

   assign rsp_tuser = rsp_item.result_kind;
   assign rsp_tdata = {6'b0,
                       rsp_item.tiles_seen,
                       rsp_item.active_count,
                       rsp_item.was_capped,
                       rsp_item.grid_fallback,
                       rsp_item.tile_selected,
                       rsp_item.tile_active,
                       rsp_item.tile_peak,
                       rsp_item.tile_number};

endmodule
`default_nettype wire

[tb/objectness_mask_tile_selector_test.sv]
// ----------------------------------------------------------------------------
// objectness_mask_tile_selector_test
// Streams clear, paint, query and end beats into the selector and checks every
// verdict and summary against a predictor that keeps its own mask, tallies and
// register copies. A directed opener is followed by randomized frames under
// several register settings, including a long run that saturates the tallies.
// ----------------------------------------------------------------------------
module objectness_mask_tile_selector_test import omts_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // box_left, box_top, box_right, box_bottom, box_confidence,
   // tile_left, tile_top, tile_width, tile_height
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // operation
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // tile_number, tile_peak, tile_active, tile_selected, grid_fallback,
   // was_capped, active_count, tiles_seen
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // result_kind
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   objectness_mask_tile_selector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // predictor state
   logic [CELL_W-1:0] mask_model [MASK_DEPTH];
   int active_tally = 0;
   int tile_tally = 0;
   int cfg_width = 640;
   int cfg_height = 640;
   int cfg_threshold = 9830;
   int cfg_fallback = 1;
   int cfg_max_tiles = 64;
   int cfg_dense = 0;

   req_type queued_requests [$];
   rsp_type predicted_results [$];
   req_type req_beat;

   int     beats_queued = 0;
   int     beats_accepted = 0;
   int     clears_seen = 0;
   int     errors = 0;
   longint work_budget = 0;
   longint cycles = 0;

   int verdict_count = 0;
   int active_verdicts = 0;
   int summary_count = 0;
   int fallback_count = 0;
   int capped_count = 0;
   int saturated_count = 0;

   // no idling on either side for a stretch in the middle of the run
   wire steady = beats_accepted >= 700 && beats_accepted < 1000;

   function automatic int pixel_to_cell(input logic [12:0] px);
      int v;
      v = int'($signed(px));
      return (v < 0) ? 0 : v / MASK_SCALE;
   endfunction

   // advance mask and tallies by one accepted beat, queue any result it yields
   task automatic run_mask_request(input req_type r);
      int mw, mh, x1, y1, x2, y2, cells;
      logic [CELL_W-1:0] peak;
      rsp_type e;
      bit act, fb;
      int chosen;
      mw = cfg_width / MASK_SCALE + 1;
      if (mw > MASK_COLS) mw = MASK_COLS;
      mh = cfg_height / MASK_SCALE + 1;
      if (mh > MASK_ROWS) mh = MASK_ROWS;
      cells = 0;
      e = '0;
      beats_accepted++;
      case (r.operation)
         OP_CLEAR: begin
            foreach (mask_model[i]) mask_model[i] = '0;
            active_tally = 0;
            tile_tally = 0;
            clears_seen++;
            // periodic full memory sweep
            if (clears_seen % 256 == 0) work_budget += 70000;
         end
         OP_PAINT: begin
            x1 = pixel_to_cell(r.box_left);
            y1 = pixel_to_cell(r.box_top);
            x2 = pixel_to_cell(r.box_right);
            y2 = pixel_to_cell(r.box_bottom);
            if (x2 > mw) x2 = mw;
            if (y2 > mh) y2 = mh;
            if (x2 > x1 && y2 > y1) begin
               cells = (x2 - x1) * (y2 - y1);
               for (int yy = y1; yy < y2; yy++)
                  for (int xx = x1; xx < x2; xx++)
                     if (mask_model[yy * MASK_COLS + xx] < r.box_confidence)
                        mask_model[yy * MASK_COLS + xx] = r.box_confidence;
            end
         end
         OP_QUERY: begin
            x1 = int'(r.tile_left) / MASK_SCALE;
            y1 = int'(r.tile_top) / MASK_SCALE;
            x2 = (int'(r.tile_left) + int'(r.tile_width)) / MASK_SCALE;
            y2 = (int'(r.tile_top) + int'(r.tile_height)) / MASK_SCALE;
            if (x2 > mw) x2 = mw;
            if (y2 > mh) y2 = mh;
            peak = '0;
            if (x2 > x1 && y2 > y1) cells = (x2 - x1) * (y2 - y1);
            for (int yy = y1; yy < y2; yy++)
               for (int xx = x1; xx < x2; xx++)
                  if (mask_model[yy * MASK_COLS + xx] > peak)
                     peak = mask_model[yy * MASK_COLS + xx];
            act = cfg_dense != 0 || int'(peak) > cfg_threshold;
            e.result_kind = KIND_VERDICT;
            e.tile_number = CNT_W'(tile_tally);
            e.tile_peak = peak;
            e.tile_active = act;
            e.tile_selected = act && active_tally < cfg_max_tiles;
            if (act && active_tally < COUNT_LIMIT) active_tally++;
            if (tile_tally < COUNT_LIMIT) tile_tally++;
            verdict_count++;
            if (act) active_verdicts++;
         end
         OP_END: begin
            fb = cfg_dense == 0 && active_tally == 0 && cfg_fallback != 0 && tile_tally > 0;
            chosen = fb ? tile_tally : active_tally;
            e.result_kind = KIND_SUMMARY;
            e.grid_fallback = fb;
            e.was_capped = chosen > cfg_max_tiles;
            summary_count++;
            if (fb) fallback_count++;
            if (e.was_capped) capped_count++;
            if (tile_tally == COUNT_LIMIT) saturated_count++;
         end
      endcase
      if (r.operation == OP_QUERY || r.operation == OP_END) begin
         e.active_count = CNT_W'(active_tally);
         e.tiles_seen = CNT_W'(tile_tally);
         predicted_results = {predicted_results, e};
      end
      work_budget += 16 + cells;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            run_mask_request(req_beat);
         end
         if (!req_tvalid || req_tready) begin
            if (queued_requests.size() != 0 && (steady || $urandom_range(99) >= 26)) begin
               req_beat = queued_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {6'b0, req_beat.tile_height, req_beat.tile_width,
                             req_beat.tile_top, req_beat.tile_left,
                             req_beat.box_confidence, req_beat.box_bottom,
                             req_beat.box_right, req_beat.box_top, req_beat.box_left};
               req_tuser <= req_beat.operation;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // monitor
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.result_kind = rsp_tuser;
            got.tile_number = rsp_tdata[9:0];
            got.tile_peak = rsp_tdata[25:10];
            got.tile_active = rsp_tdata[26];
            got.tile_selected = rsp_tdata[27];
            got.grid_fallback = rsp_tdata[28];
            got.was_capped = rsp_tdata[29];
            got.active_count = rsp_tdata[39:30];
            got.tiles_seen = rsp_tdata[49:40];
            if (predicted_results.size() == 0) begin
               $display("%0t: unexpected result beat: expected none, actual kind %0d data %h",
                        $time, got.result_kind, rsp_tdata);
               errors++;
            end else begin
               want = predicted_results.pop_front();
               check_field("result_kind", want.result_kind, got.result_kind);
               check_field("tile_number", want.tile_number, got.tile_number);
               check_field("tile_peak", want.tile_peak, got.tile_peak);
               check_field("tile_active", want.tile_active, got.tile_active);
               check_field("tile_selected", want.tile_selected, got.tile_selected);
               check_field("grid_fallback", want.grid_fallback, got.grid_fallback);
               check_field("was_capped", want.was_capped, got.was_capped);
               check_field("active_count", want.active_count, got.active_count);
               check_field("tiles_seen", want.tiles_seen, got.tiles_seen);
            end
         end
         rsp_tready <= steady || $urandom_range(99) >= 26;
      end
   end

   // watchdog scaled to the work accepted so far; covers the sweep after reset
   always @(posedge clock) begin
      cycles++;
      if (cycles > 300000 + 4 * work_budget) begin
         $display("cycle limit hit with %0d results outstanding", predicted_results.size());
         $display("objectness_mask_tile_selector_test failed");
         $finish;
      end
   end

   function automatic req_type random_req();
      req_type r;
      r.operation = op_type'($urandom_range(0, 3));
      r.box_left = 13'($urandom);
      r.box_top = 13'($urandom);
      r.box_right = 13'($urandom);
      r.box_bottom = 13'($urandom);
      r.box_confidence = 16'($urandom);
      r.tile_left = 11'($urandom);
      r.tile_top = 11'($urandom);
      r.tile_width = 12'($urandom_range(1, 2048));
      r.tile_height = 12'($urandom_range(1, 2048));
      return r;
   endfunction

   task automatic enqueue(input req_type r);
      queued_requests = {queued_requests, r};
      beats_queued++;
   endtask

   task automatic push_op(input op_type op);
      req_type r;
      r = random_req();
      r.operation = op;
      enqueue(r);
   endtask

   task automatic push_box(input int l, input int t, input int rt, input int b, input int cf);
      req_type r;
      r = random_req();
      r.operation = OP_PAINT;
      r.box_left = 13'(l);
      r.box_top = 13'(t);
      r.box_right = 13'(rt);
      r.box_bottom = 13'(b);
      r.box_confidence = 16'(cf);
      enqueue(r);
   endtask

   task automatic push_tile(input int l, input int t, input int w, input int h);
      req_type r;
      r = random_req();
      r.operation = OP_QUERY;
      r.tile_left = 11'(l);
      r.tile_top = 11'(t);
      r.tile_width = 12'(w);
      r.tile_height = 12'(h);
      enqueue(r);
   endtask

   // one frame: optional clear, a few boxes, a row-major tile walk, end of grid
   task automatic push_frame(input bit may_clear, input bit heavy);
      int np, nq, tw, th, per_row, bx, by, bw, bh, cf, tl, tt;
      bit big;
      if (may_clear && $urandom_range(99) < 80) push_op(OP_CLEAR);
      np = heavy ? $urandom_range(0, 2) : $urandom_range(0, 6);
      repeat (np) begin
         bx = int'($urandom_range(0, cfg_width + 16)) - 16;
         by = int'($urandom_range(0, cfg_height + 16)) - 16;
         big = !heavy && $urandom_range(99) < 3;
         bw = $urandom_range(0, big ? 4095 : 80);
         bh = $urandom_range(0, big ? 4095 : 80);
         case ($urandom_range(0, 3))
            0: cf = cfg_threshold + int'($urandom_range(0, 2)) - 1;
            1: cf = $urandom_range(0, 1) ? 65535 : 0;
            default: cf = $urandom_range(0, 65535);
         endcase
         if (cf < 0) cf = 0;
         if (cf > 65535) cf = 65535;
         push_box(bx, by, (bx + bw > 4095) ? 4095 : bx + bw,
                  (by + bh > 4095) ? 4095 : by + bh, cf);
      end
      nq = heavy ? $urandom_range(10, 40) : $urandom_range(1, 12);
      tw = heavy ? $urandom_range(8, 32) : $urandom_range(8, 128);
      th = heavy ? $urandom_range(8, 32) : $urandom_range(8, 128);
      per_row = cfg_width / tw + 1;
      for (int i = 0; i < nq; i++) begin
         if (!heavy && $urandom_range(99) < 3) begin
            push_tile($urandom_range(0, 2047), $urandom_range(0, 2047),
                      $urandom_range(1, 2048), $urandom_range(1, 2048));
         end else begin
            tl = (i % per_row) * tw;
            tt = (i / per_row) * th;
            push_tile((tl > 2047) ? 2047 : tl, (tt > 2047) ? 2047 : tt, tw, th);
         end
      end
      push_op(OP_END);
   endtask

   task automatic gen_phase(input int n, input int noise_pct, input bit may_clear,
                            input bit heavy);
      int target;
      target = beats_queued + n;
      while (beats_queued < target) begin
         if ($urandom_range(99) < noise_pct) enqueue(random_req());
         else push_frame(may_clear, heavy);
      end
      // close on a beat that answers, so the block is idle once it has answered
      push_op(OP_END);
   endtask

   task automatic drain();
      while (beats_accepted != beats_queued || predicted_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input int val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(val);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:  cfg_width = val & 'h7FF;
         CSR_IMAGE_HEIGHT: cfg_height = val & 'h7FF;
         CSR_THRESHOLD:    cfg_threshold = val & 'hFFFF;
         CSR_FALLBACK:     cfg_fallback = val & 1;
         CSR_MAX_TILES:    cfg_max_tiles = val & 'h3FF;
         CSR_DENSE:        cfg_dense = val & 1;
         default: ;
      endcase
   endtask

   task automatic set_config(input int w, input int h, input int thr, input int fb,
                             input int mt, input int dn);
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
      write_csr(CSR_THRESHOLD, thr);
      write_csr(CSR_FALLBACK, fb);
      write_csr(CSR_MAX_TILES, mt);
      write_csr(CSR_DENSE, dn);
   endtask

   initial begin
      foreach (mask_model[i]) mask_model[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed opener under reset settings (81 x 81 cells)
      push_op(OP_END);                         // summary with no tiles
      push_op(OP_CLEAR);
      push_tile(0, 0, 64, 64);                 // empty mask
      push_op(OP_END);                         // fallback
      push_box(-4096, -100, 4095, 4095, 65535);  // whole mask, negative start
      push_tile(0, 0, 2048, 2048);
      push_op(OP_CLEAR);
      push_box(-50, 0, -1, 100, 100);          // negative right edge
      push_box(8, 8, 15, 15, 500);             // under one cell
      push_box(100, 100, 50, 200, 500);        // inverted
      push_tile(0, 0, 2048, 2048);
      push_box(16, 16, 48, 40, 9830);          // equal to threshold
      push_tile(0, 0, 64, 64);
      push_box(24, 24, 32, 32, 9831);
      push_box(24, 24, 32, 32, 5);             // lower value must not win
      push_tile(0, 0, 64, 64);
      push_tile(2047, 2047, 1, 1);             // outside the mask
      push_tile(0, 0, 7, 7);                   // covers no cell
      push_box(600, 600, 4095, 4095, 40000);   // past the mask edge
      push_tile(640, 640, 8, 8);
      push_box(0, 0, 8, 8, 0);
      push_op(OP_END);
      push_op(OP_CLEAR);
      push_op(OP_END);
      drain();

      set_config(2047, 2047, 0, 0, 0, 0);
      gen_phase(70, 15, 1'b1, 1'b0);
      drain();
      set_config(1, 1, 65535, 1, 1023, 0);
      gen_phase(60, 15, 1'b1, 1'b0);
      drain();
      set_config($urandom_range(1, 2047), $urandom_range(1, 2047), $urandom_range(0, 65535),
                 $urandom_range(0, 1), $urandom_range(0, 1023), $urandom_range(0, 1));
      gen_phase(70, 15, 1'b1, 1'b0);
      drain();
      // long frames without clears drive both tallies into saturation
      set_config($urandom_range(1, 2047), $urandom_range(1, 2047), $urandom_range(0, 65535),
                 1, 1023, 1);
      gen_phase(550, 0, 1'b0, 1'b1);
      drain();
      set_config(2047, $urandom_range(1, 2047), $urandom_range(0, 65535), 0, 700, 1);
      gen_phase(550, 0, 1'b0, 1'b1);
      drain();
      set_config($urandom_range(1, 2047), $urandom_range(1, 2047), $urandom_range(0, 2000),
                 1, $urandom_range(1, 8), 0);
      gen_phase(80, 15, 1'b1, 1'b0);
      drain();
      set_config($urandom_range(1, 2047), $urandom_range(1, 2047), $urandom_range(0, 65535),
                 $urandom_range(0, 1), $urandom_range(0, 1023), $urandom_range(0, 1));
      gen_phase(60, 20, 1'b1, 1'b0);
      drain();
      repeat (16) @(posedge clock);

      $display("run: %0d request beats, %0d clears, %0d verdicts (%0d active)",
               beats_accepted, clears_seen, verdict_count, active_verdicts);
      $display("run: %0d summaries, %0d fallback, %0d capped, %0d at saturated tallies",
               summary_count, fallback_count, capped_count, saturated_count);
      if (errors == 0 && predicted_results.size() == 0) begin
         $display("objectness_mask_tile_selector_test passed");
      end else begin
         $display("objectness_mask_tile_selector_test failed");
      end
      $finish;
   end

endmodule

[objectness_mask_tile_selector.f]
rtl/core/omts_pkg.sv
rtl/core/omts_mask_ram.sv
rtl/core/omts_ctrl.sv
rtl/core/omts_datapath.sv
rtl/core/objectness_mask_tile_selector.sv
tb/objectness_mask_tile_selector_test.sv
